// ===== design/drrip_stream_bypass_replacement_top_macros.svh =====
// assertion macros for the drrip replacement block
// used by the checker module only
`ifndef DRRIP_STREAM_BYPASS_REPLACEMENT_TOP_MACROS_SVH
`define DRRIP_STREAM_BYPASS_REPLACEMENT_TOP_MACROS_SVH
`define DRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== design/drp_pkg.sv =====
// package for the drrip replacement block
// types and constants shared by drp_stream, drp_rrpv and the top, no dependencies
`default_nettype none
package drp_pkg;
	localparam int SET_COUNT = 2048;
	localparam int WAY_COUNT = 16;
	localparam logic [1:0] RRPV_MAX = 2'd3;
	localparam logic [7:0] SCORE_MAX = 8'd255;
	localparam logic [7:0] THRESH_RESET = 8'd32;
	localparam logic [0:0] KIND_VICTIM = 1'b0;
	localparam logic [0:0] KIND_UPDATE = 1'b1;
	localparam logic [0:0] REG_THRESH = 1'b0;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WORK,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== design/drp_stream.sv =====
// per-set stride detector held in one synchronous memory row per set
// depends on drp_pkg
`default_nettype none
module drp_stream #(
	parameter int SETS = 2048,
	parameter int SET_W = 11
) (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [SET_W-1:0] rd_set,
	input  wire logic [63:0]      addr,
	input  wire logic [7:0]       thresh,
	input  wire logic             wr_en,
	input  wire logic             clr_en,
	input  wire logic [SET_W-1:0] wr_set,
	output logic                  stream
);
	logic [135:0] mem [SETS];
	logic [135:0] row_s1;
	logic [63:0] stride;
	logic [7:0] score_old, score_new;
	logic [135:0] wdata;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_s1 <= mem[rd_set];
		end
		if (clr_en) begin
			mem[wr_set] <= '0;
		end else if (wr_en) begin
			mem[wr_set] <= wdata;
		end
	end

	always_comb begin
		stride = addr - row_s1[63:0];
		score_old = row_s1[135:128];
		if (stride == row_s1[127:64] && stride != 64'd0) begin
			score_new = (score_old < drp_pkg::SCORE_MAX) ? score_old + 8'd1 : score_old;
		end else begin
			score_new = (score_old > 8'd0) ? score_old - 8'd1 : score_old;
		end
		wdata = {score_new, stride, addr};
		stream = score_new >= thresh;
	end
endmodule
`default_nettype wire

// ===== design/drp_rrpv.sv =====
// rrpv row memory, one row of ways per set, with age and victim search
// depends on drp_pkg
`default_nettype none
module drp_rrpv #(
	parameter int SETS = 2048,
	parameter int SET_W = 11,
	parameter int WAYS = 16,
	parameter int WAY_W = 4
) (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [SET_W-1:0] rd_set,
	input  wire logic             wr_en,
	input  wire logic             clr_en,
	input  wire logic             upd,
	input  wire logic [SET_W-1:0] wr_set,
	input  wire logic [WAY_W-1:0] way,
	input  wire logic [1:0]       ins,
	output logic [WAY_W-1:0]      victim
);
	logic [2*WAYS-1:0] mem [SETS];
	logic [2*WAYS-1:0] row_s1, aged, wdata;
	logic [WAYS-1:0] at3, at2, at1;
	logic [1:0] top, add;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_s1 <= mem[rd_set];
		end
		if (clr_en) begin
			mem[wr_set] <= '1;
		end else if (wr_en) begin
			mem[wr_set] <= wdata;
		end
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			at3[w] = row_s1[2*w +: 2] == drp_pkg::RRPV_MAX;
			at2[w] = row_s1[2*w +: 2] == 2'd2;
			at1[w] = row_s1[2*w +: 2] == 2'd1;
		end
		if (|at3) top = drp_pkg::RRPV_MAX;
		else if (|at2) top = 2'd2;
		else if (|at1) top = 2'd1;
		else top = 2'd0;
		add = drp_pkg::RRPV_MAX - top;
		aged = row_s1;
		for (int w = 0; w < WAYS; w++) begin
			aged[2*w +: 2] = row_s1[2*w +: 2] + add;
		end
		victim = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (aged[2*w +: 2] == drp_pkg::RRPV_MAX) victim = WAY_W'(w);
		end
		wdata = aged;
		if (upd) begin
			wdata = row_s1;
			wdata[2*way +: 2] = ins;
		end
	end
endmodule
`default_nettype wire

// ===== design/drrip_stream_bypass_replacement_top.sv =====
// drrip replacement top: control, selector and config port
// depends on drp_pkg, drp_rrpv, drp_stream
//
// usage: one input channel carries victim requests (kind 0) and access
// updates (kind 1); one output channel returns one beat per input beat.
// each beat reads its set's rrpv row and stride row from synchronous
// memories at acceptance, modifies them and writes the rrpv row back (the
// stride row for updates only) in the next cycle, where the result is
// registered: out_valid rises in ST_OUT, after the beat has passed the
// input registers and then the result registers. a new beat is taken in
// the cycle the previous result leaves, so a beat is not taken while one
// is in flight, a limit set by the read-modify-write of one memory row.
// after reset the block sweeps every set once to load rrpv 3 and zero
// stride state; no beat is taken meanwhile, config writes are taken. when
// the receiver stalls, the result holds and the next beat waits in its
// input until the result leaves. stream_threshold lies at apb address 0.
`default_nettype none
module drrip_stream_bypass_replacement_top #(
	parameter int LEADER_PAIRS = 64,
	parameter int SELECTOR_BITS = 10
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          kind,
	input  wire logic [10:0]                   set_index,
	input  wire logic [3:0]                    way_index,
	input  wire logic [63:0]                   address,
	input  wire logic                          was_hit,
	input  wire logic [4:0]                    random_draw,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [3:0]                         victim_way,
	output logic                               streaming,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [1:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	localparam int SET_W = $clog2(drp_pkg::SET_COUNT);
	localparam int WAY_W = $clog2(drp_pkg::WAY_COUNT);
	localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
	localparam logic [SELECTOR_BITS-1:0] SEL_MID = SELECTOR_BITS'(1) << (SELECTOR_BITS - 1);
	localparam int LEAD_SETS = 2 * LEADER_PAIRS;

	drp_pkg::state_t state_q, state_d;
	logic [SET_W-1:0] clr_q;
	logic [7:0] thresh_q;
	logic [SELECTOR_BITS-1:0] psel_q;
	logic kind_q, hit_q;
	logic [SET_W-1:0] set_q;
	logic [WAY_W-1:0] way_q;
	logic [63:0] addr_q;
	logic [4:0] draw_q;
	logic accept, clearing, working, sr_lead, br_lead, stream;
	logic [1:0] ins;
	logic [WAY_W-1:0] victim;
	logic [SET_W-1:0] rd_set, wr_set;

	assign pready = 1'b1;
	assign prdata = {24'd0, thresh_q};
	assign accept = in_valid && !in_stall;
	assign clearing = state_q == drp_pkg::ST_CLEAR;
	assign working = state_q == drp_pkg::ST_WORK;
	assign rd_set = set_index[SET_W-1:0];
	assign wr_set = clearing ? clr_q : set_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			drp_pkg::ST_CLEAR: if (clr_q == SET_W'(drp_pkg::SET_COUNT - 1)) state_d = drp_pkg::ST_IDLE;
			drp_pkg::ST_IDLE:  if (in_valid) state_d = drp_pkg::ST_WORK;
			drp_pkg::ST_WORK:  state_d = drp_pkg::ST_OUT;
			drp_pkg::ST_OUT: begin
				if (!out_stall) state_d = in_valid ? drp_pkg::ST_WORK : drp_pkg::ST_IDLE;
			end
			default: state_d = drp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			drp_pkg::ST_IDLE: in_stall = 1'b0;
			drp_pkg::ST_OUT: begin
				out_valid = 1'b1;
				in_stall = out_stall;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_comb begin
		sr_lead = 32'(set_q) < LEAD_SETS && !set_q[0];
		br_lead = 32'(set_q) < LEAD_SETS && set_q[0];
		if (stream) ins = drp_pkg::RRPV_MAX;
		else if (sr_lead) ins = 2'd2;
		else if (!br_lead && psel_q >= SEL_MID) ins = 2'd2;
		else ins = (draw_q == 5'd0) ? 2'd2 : 2'd3;
		if (hit_q) ins = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drp_pkg::ST_CLEAR;
			clr_q <= '0;
			thresh_q <= drp_pkg::THRESH_RESET;
			psel_q <= SEL_MID;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + SET_W'(1);
			if (psel && penable && pwrite && paddr[1:0] == {drp_pkg::REG_THRESH, 1'b0}) begin
				thresh_q <= pwdata[7:0];
			end
			if (working && kind_q == drp_pkg::KIND_UPDATE && hit_q) begin
				if (sr_lead && psel_q < SEL_MAX) psel_q <= psel_q + SELECTOR_BITS'(1);
				if (br_lead && psel_q > '0) psel_q <= psel_q - SELECTOR_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			set_q <= set_index[SET_W-1:0];
			way_q <= way_index[WAY_W-1:0];
			addr_q <= address;
			hit_q <= was_hit;
			draw_q <= random_draw;
		end
		if (working) begin
			victim_way <= (kind_q == drp_pkg::KIND_VICTIM) ? 4'(victim) : 4'd0;
			streaming <= (kind_q == drp_pkg::KIND_UPDATE) ? stream : 1'b0;
		end
	end

	drp_rrpv #(.SETS(drp_pkg::SET_COUNT), .SET_W(SET_W), .WAYS(drp_pkg::WAY_COUNT),
		.WAY_W(WAY_W)) u_rrpv (
		.clk(clk), .rd_en(accept), .rd_set(rd_set), .wr_en(working),
		.clr_en(clearing), .upd(kind_q), .wr_set(wr_set), .way(way_q), .ins(ins),
		.victim(victim)
	);

	drp_stream #(.SETS(drp_pkg::SET_COUNT), .SET_W(SET_W)) u_stream (
		.clk(clk), .rd_en(accept), .rd_set(rd_set), .addr(addr_q), .thresh(thresh_q),
		.wr_en(working && kind_q == drp_pkg::KIND_UPDATE), .clr_en(clearing),
		.wr_set(wr_set), .stream(stream)
	);
endmodule
`default_nettype wire

// ===== design/drp_checker.sv =====
// port-level checker for the drrip replacement top, with its bind
// depends on the macros header
`default_nettype none
`include "drrip_stream_bypass_replacement_top_macros.svh"
module drp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [3:0] victim_way,
	input wire logic streaming
);
	`DRP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(victim_way))
	`DRP_ASSERT_NEXT(a_no_out_after_in, clk, arst_n, in_valid && !in_stall, !out_valid)
	`DRP_ASSERT_IMPL(a_one_field, clk, arst_n, out_valid, !(streaming && victim_way != 4'd0))
endmodule

bind drrip_stream_bypass_replacement_top drp_checker u_drp_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .victim_way(victim_way),
	.streaming(streaming)
);
`default_nettype wire
